### hdl/sids_pkg.sv
// Shared types and constants for the searchable screen-identifier stack.
// Holds the command encoding, field widths and the controller/datapath structs.
// No dependencies.
`default_nettype none

package sids_pkg;

  localparam int DEF_STACK_DEPTH = 16;
  localparam int DEF_ID_BITS     = 8;

  // A walk never emits more words than this.
  localparam int MAX_RESULTS = 16;
  localparam int WALK_CNT_W  = $clog2(MAX_RESULTS);

  localparam int OP_W       = 3;
  localparam int SID_W      = 8;
  localparam int LAYER_W    = 4;
  localparam int DEPTH_W    = 5;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR    = 3'd0,
    OP_PUSH     = 3'd1,
    OP_READ_TOP = 3'd2,
    OP_READ_AT  = 3'd3,
    OP_FIND     = 3'd4,
    OP_DELETE   = 3'd5,
    OP_WALK     = 3'd6
  } op_t;

  typedef struct packed {
    logic cmd_load;
    logic fill_clr;
    logic fill_inc;
    logic fill_dec;
    logic push_wr;
    logic shift_wr;
    logic idx_ld_top;
    logic idx_ld_lay;
    logic idx_inc;
    logic idx_dec;
    logic rd_en;
    logic rd_next;
    logic cnt_clr;
    logic cnt_inc;
    logic out_load;
    logic res_ok;
    logic res_use_id;
    logic res_use_lay;
    logic res_last;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic lay_lt_fill;
    logic idx_zero;
    logic next_lt_fill;
    logic hit;
    logic walk_fin;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

### hdl/sids_dp.sv
// Datapath of the screen-identifier stack: command capture, entry memory,
// fill count, layer index, walk counter and the output word register.
// Depends on sids_pkg.
`default_nettype none

module sids_dp import sids_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int ID_BITS     = DEF_ID_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic                  out_last
);

  localparam int IDX_W = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int CMP_W = ((CNT_W > LAYER_W) ? CNT_W : LAYER_W) + 1;

  logic [ID_BITS-1:0]    mem_r [STACK_DEPTH];
  logic [ID_BITS-1:0]    rd_data_r;

  op_t                   op_r, op_nxt;
  logic [ID_BITS-1:0]    sid_r, sid_nxt;
  logic [LAYER_W-1:0]    lay_r, lay_nxt;
  logic [CNT_W-1:0]      fill_r, fill_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [WALK_CNT_W-1:0] wcnt_r, wcnt_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_ok_r, out_ok_nxt;
  logic [SID_W-1:0]      out_sid_r, out_sid_nxt;
  logic [LAYER_W-1:0]    out_lay_r, out_lay_nxt;
  logic [DEPTH_W-1:0]    out_depth_r, out_depth_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [ID_BITS-1:0]    wr_data;
  logic [IDX_W-1:0]      rd_addr;
  logic [CMP_W-1:0]      fill_ext;
  logic [CMP_W-1:0]      next_ext;
  logic                  next_lt_fill;
  logic                  out_free;

  assign fill_ext     = CMP_W'(fill_r);
  assign next_ext     = CMP_W'(idx_r) + CMP_W'(1);
  assign next_lt_fill = next_ext < fill_ext;
  assign out_free     = !out_valid_r || out_ready;

  always_comb begin
    stat.op           = op_r;
    stat.full         = fill_r == CNT_W'(STACK_DEPTH);
    stat.empty        = fill_r == '0;
    stat.lay_lt_fill  = CMP_W'(lay_r) < fill_ext;
    stat.idx_zero     = idx_r == '0;
    stat.next_lt_fill = next_lt_fill;
    stat.hit          = rd_data_r == sid_r;
    stat.walk_fin     = !next_lt_fill || (wcnt_r == WALK_CNT_W'(MAX_RESULTS - 1));
    stat.out_free     = out_free;
  end

  // One write port shared by push and the delete shift; one registered read port.
  assign wr_en   = cmd.push_wr || cmd.shift_wr;
  assign wr_addr = cmd.push_wr ? IDX_W'(fill_r) : idx_r;
  assign wr_data = cmd.push_wr ? sid_r : rd_data_r;
  assign rd_addr = cmd.rd_next ? (idx_r + IDX_W'(1)) : idx_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  always_comb begin
    op_nxt  = op_r;
    sid_nxt = sid_r;
    lay_nxt = lay_r;
    if (cmd.cmd_load) begin
      op_nxt  = op_t'(in_data[OP_W-1:0]);
      sid_nxt = ID_BITS'(in_data[OP_W +: SID_W]);
      lay_nxt = in_data[OP_W+SID_W +: LAYER_W];
    end

    fill_nxt = fill_r;
    priority if (cmd.fill_clr) begin
      fill_nxt = '0;
    end else if (cmd.fill_inc) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (cmd.fill_dec) begin
      fill_nxt = fill_r - CNT_W'(1);
    end

    idx_nxt = idx_r;
    priority if (cmd.idx_ld_top) begin
      idx_nxt = IDX_W'(fill_r - CNT_W'(1));
    end else if (cmd.idx_ld_lay) begin
      idx_nxt = IDX_W'(lay_r);
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + IDX_W'(1);
    end else if (cmd.idx_dec) begin
      idx_nxt = idx_r - IDX_W'(1);
    end

    wcnt_nxt = wcnt_r;
    priority if (cmd.cnt_clr) begin
      wcnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      wcnt_nxt = wcnt_r + WALK_CNT_W'(1);
    end

    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_sid_nxt   = out_sid_r;
    out_lay_nxt   = out_lay_r;
    out_depth_nxt = out_depth_r;
    out_last_nxt  = out_last_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_ok_nxt    = cmd.res_ok;
      out_sid_nxt   = cmd.res_use_id ? SID_W'(rd_data_r) : '0;
      out_lay_nxt   = cmd.res_use_lay ? LAYER_W'(idx_r) : '0;
      out_depth_nxt = DEPTH_W'(fill_r);
      out_last_nxt  = cmd.res_last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    sid_r       <= sid_nxt;
    lay_r       <= lay_nxt;
    idx_r       <= idx_nxt;
    wcnt_r      <= wcnt_nxt;
    out_ok_r    <= out_ok_nxt;
    out_sid_r   <= out_sid_nxt;
    out_lay_r   <= out_lay_nxt;
    out_depth_r <= out_depth_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_last  = out_last_r;
  assign out_data  = OUT_DATA_W'({out_depth_r, out_lay_r, out_sid_r, out_ok_r});

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(STACK_DEPTH))
    else $error("fill count exceeds the stack depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_wr |-> (fill_r < CNT_W'(STACK_DEPTH)))
    else $error("push written into a full stack");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("output word overwritten while still pending");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (fill_r != $past(fill_r))) |->
      ((fill_r == '0) || (fill_r == $past(fill_r) + CNT_W'(1)) ||
       (fill_r == $past(fill_r) - CNT_W'(1))))
    else $error("fill count moved by more than one entry");

endmodule

`default_nettype wire

### hdl/sids_ctrl.sv
// Controller of the screen-identifier stack: sequences each command through
// reads, scans, shifts and output words of the datapath.
// Depends on sids_pkg.
`default_nettype none

module sids_ctrl import sids_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_READ,
    S_FIND_RD,
    S_FIND_CHK,
    S_DEL_RD,
    S_DEL_WR,
    S_WALK_RD,
    S_WALK_OUT,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   res_ok_r, res_ok_nxt;
  logic   res_id_r, res_id_nxt;
  logic   res_lay_r, res_lay_nxt;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    res_ok_nxt  = res_ok_r;
    res_id_nxt  = res_id_r;
    res_lay_nxt = res_lay_r;

    unique case (state_r)
      S_IDLE: begin
        cmd.cmd_load = in_valid;
        if (in_valid) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        res_ok_nxt  = 1'b0;
        res_id_nxt  = 1'b0;
        res_lay_nxt = 1'b0;
        state_nxt   = S_EMIT;
        unique case (stat.op)
          OP_CLEAR: begin
            cmd.fill_clr = 1'b1;
            res_ok_nxt   = 1'b1;
          end
          OP_PUSH: begin
            if (!stat.full) begin
              cmd.push_wr  = 1'b1;
              cmd.fill_inc = 1'b1;
              res_ok_nxt   = 1'b1;
            end
          end
          OP_READ_TOP: begin
            if (!stat.empty) begin
              cmd.idx_ld_top = 1'b1;
              res_ok_nxt     = 1'b1;
              res_id_nxt     = 1'b1;
              state_nxt      = S_READ;
            end
          end
          OP_READ_AT: begin
            if (stat.lay_lt_fill) begin
              cmd.idx_ld_lay = 1'b1;
              res_ok_nxt     = 1'b1;
              res_id_nxt     = 1'b1;
              state_nxt      = S_READ;
            end
          end
          OP_FIND: begin
            if (!stat.empty) begin
              cmd.idx_ld_top = 1'b1;
              state_nxt      = S_FIND_RD;
            end
          end
          OP_DELETE: begin
            if (stat.lay_lt_fill) begin
              cmd.idx_ld_lay = 1'b1;
              state_nxt      = S_DEL_RD;
            end
          end
          OP_WALK: begin
            if (stat.lay_lt_fill) begin
              cmd.idx_ld_lay = 1'b1;
              cmd.cnt_clr    = 1'b1;
              state_nxt      = S_WALK_RD;
            end
          end
          default: begin
            // Undefined opcode: a single failed word, nothing changes.
          end
        endcase
      end

      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_EMIT;
      end

      S_FIND_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_FIND_CHK;
      end

      // The scan runs from the top down, so the first hit is the topmost layer.
      S_FIND_CHK: begin
        priority if (stat.hit) begin
          res_ok_nxt  = 1'b1;
          res_lay_nxt = 1'b1;
          state_nxt   = S_EMIT;
        end else if (stat.idx_zero) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.idx_dec = 1'b1;
          state_nxt   = S_FIND_RD;
        end
      end

      S_DEL_RD: begin
        if (stat.next_lt_fill) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_next = 1'b1;
          state_nxt   = S_DEL_WR;
        end else begin
          cmd.fill_dec = 1'b1;
          res_ok_nxt   = 1'b1;
          state_nxt    = S_EMIT;
        end
      end

      S_DEL_WR: begin
        cmd.shift_wr = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_nxt    = S_DEL_RD;
      end

      S_WALK_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_WALK_OUT;
      end

      S_WALK_OUT: begin
        cmd.res_ok      = 1'b1;
        cmd.res_use_id  = 1'b1;
        cmd.res_use_lay = 1'b1;
        cmd.res_last    = stat.walk_fin;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (stat.walk_fin) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            cmd.cnt_inc = 1'b1;
            state_nxt   = S_WALK_RD;
          end
        end
      end

      S_EMIT: begin
        cmd.res_ok      = res_ok_r;
        cmd.res_use_id  = res_id_r;
        cmd.res_use_lay = res_lay_r;
        cmd.res_last    = 1'b1;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      res_ok_r  <= 1'b0;
      res_id_r  <= 1'b0;
      res_lay_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      res_ok_r  <= res_ok_nxt;
      res_id_r  <= res_id_nxt;
      res_lay_r <= res_lay_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/searchable_id_stack_unit.sv
// Searchable stack of screen identifiers: clear, push, read top, read at a
// layer, find, delete at a layer with shift-down, and walk to the top.
//
// Input words arrive on in_tvalid/in_tready/in_tdata, one command per word.
// Result words leave on out_tvalid/out_tready/out_tdata/out_tlast; every
// command gives one word with out_tlast set, except a walk, which gives one
// word per entry from the start layer up and sets out_tlast on the final one.
// Each word reports the stack depth after the command.
//
// One command is handled at a time; in_tready is high only while the
// controller is idle. After accept, a clear, push or failed command passes the
// decode state and then loads its word in the emit state; a read passes a read
// state between the two. Find steps per entry scanned from the top, delete
// per entry shifted down, walk per emitted word: each step is one access of
// the entry memory followed by a compare, a write-back or an output load.
// The output word sits in a register, so the next command is accepted while
// a finished word still waits; when the receiver stalls, the controller holds
// at its next output word until out_tready frees the register.
// Reset empties the stack and drops any pending word; the entry memory itself
// is not cleared, no command reads an entry before it is written.
`default_nettype none

module searchable_id_stack_unit import sids_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int ID_BITS     = DEF_ID_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // op[2:0], screen_id[10:3], layer[14:11]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // ok[0], screen_id[8:1], layer[12:9], depth[17:13]
  output logic                  out_tlast
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sids_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sids_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

`default_nettype wire
